// File: design/lpl_pkg.sv
// lookahead peak limiter: shared constants, register indexes and reset values
// no dependencies; used by the interfaces, lpl_div, the core and the testbench
package lpl_pkg;

    localparam int LOOKAHEAD_DEF   = 64;
    localparam int DEQUE_DEPTH_DEF = 128;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CEIL_W     = 23;
    localparam int COEF_W     = 24;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 23;
    localparam int STAMP_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h800000;
    localparam logic [COEF_W:0]   COEF_ONE = 25'h1000000;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING_LEVEL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF  = 8'd3;

    localparam logic              MODE_RST    = 1'b1;
    localparam logic [CEIL_W-1:0] CEILING_RST = 23'd4194304;
    localparam logic [COEF_W-1:0] ATTACK_RST  = 24'd15760000;
    localparam logic [COEF_W-1:0] RELEASE_RST = 24'd16770000;

endpackage

// File: design/lpl_ifs.sv
// lookahead peak limiter: sample, result and configuration channel interfaces
// depends on lpl_pkg
interface lpl_sample_if #(parameter int SB = lpl_pkg::SAMPLE_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] left_in;
    logic signed [SB-1:0] right_in;
    modport source (output valid, left_in, right_in, input ready);
    modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface lpl_result_if #(parameter int SB = lpl_pkg::SAMPLE_BITS_DEF);
    logic                              valid;
    logic                              ready;
    logic signed [SB-1:0]              left_out;
    logic signed [SB-1:0]              right_out;
    logic [lpl_pkg::GAIN_W-1:0]        gain_now;
    modport source (output valid, left_out, right_out, gain_now, input ready);
    modport sink   (input valid, left_out, right_out, gain_now, output ready);
endinterface

interface lpl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lpl_pkg::CFG_IDX_W-1:0]  index;
    logic [lpl_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/lpl_div.sv
// lookahead peak limiter: restoring divider, one quotient bit per cycle
// computes (ceiling << 23) / peak for peak > ceiling; depends on lpl_pkg
module lpl_div #(
    parameter int PW = lpl_pkg::SAMPLE_BITS_DEF - 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lpl_pkg::CEIL_W-1:0]    num,
    input  logic [PW-1:0]                 den,
    output logic                          done,
    output logic [lpl_pkg::GAIN_FRAC-1:0] quot
);
    localparam int QB    = lpl_pkg::GAIN_FRAC;
    localparam int CNT_W = $clog2(QB + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    den_reg, den_next;
    logic [QB-1:0]    q_reg, q_next;
    logic [PW:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        trial     = {rem_reg, 1'b0};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QB);
            rem_next  = PW'(num);
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // numerator low bits are all zero, so shift in zeros
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = PW'(trial - {1'b0, den_reg});
                q_next   = {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PW-1:0];
                q_next   = {q_reg[QB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// File: design/lpl_mul.sv
// lookahead peak limiter: shared multiplier with registered product
// used for both smoothing products and both sample scalings; no dependencies
module lpl_mul #(
    parameter int AW = 25,
    parameter int BW = 24
) (
    input  logic               clk,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic [AW+BW-1:0]   prod
);
    logic [AW+BW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (AW+BW)'(a) * (AW+BW)'(b);
    end

    assign prod = prod_reg;
endmodule

// File: design/lookahead_peak_limiter_core.sv
// lookahead peak limiter top level: sequencer, deque and delay memories
// depends on lpl_pkg, lpl_ifs, lpl_div and lpl_mul
//
// One sample pair per item, limited against a sliding-window peak over the
// last LOOKAHEAD items and delayed by LOOKAHEAD items. The block works on one
// item at a time: it drops smaller deque entries at the back, pushes the new
// peak, drops expired entries at the front, runs the 23-step divider only when
// the window peak is above the ceiling, then smooths the gain and scales the
// delayed samples through the shared multiplier. Each deque pop is a read of
// the deque memory.
// The result sits in an output register, so the next item is taken while it
// waits. After reset a clearing pass over all LOOKAHEAD entries zeroes the delay
// lines before the first item is accepted; configuration writes are taken at
// any time and must only be issued while the block is idle.
module lookahead_peak_limiter_core #(
    parameter int LOOKAHEAD   = lpl_pkg::LOOKAHEAD_DEF,
    parameter int DEQUE_DEPTH = lpl_pkg::DEQUE_DEPTH_DEF,
    parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lpl_sample_if.sink    sample_in,
    lpl_result_if.source  result_out,
    lpl_cfg_if.sink       cfg
);
    localparam int SB     = SAMPLE_BITS;
    localparam int PW     = SB - 1;
    localparam int SW     = lpl_pkg::STAMP_W;
    localparam int CW     = lpl_pkg::CEIL_W;
    localparam int KW     = lpl_pkg::COEF_W;
    localparam int GW     = lpl_pkg::GAIN_W;
    localparam int GF     = lpl_pkg::GAIN_FRAC;
    localparam int DQ_W   = $clog2(DEQUE_DEPTH);
    localparam int LA_W   = $clog2(LOOKAHEAD);
    localparam int MW     = (SB > KW + 1) ? SB : KW + 1;
    localparam int PRD_W  = MW + GW;
    localparam int CMP_W  = (PW > CW) ? PW : CW;
    localparam int EXT_W  = (SB > CW) ? SB : CW;
    localparam int RND_W  = PRD_W + 1 - GF;
    localparam logic [PW-1:0] PEAK_MAX = {PW{1'b1}};

    typedef enum logic [14:0] {
        S_CLR       = 15'h0001,
        S_IDLE      = 15'h0002,
        S_BACK_RD   = 15'h0004,
        S_BACK_CHK  = 15'h0008,
        S_PUSH      = 15'h0010,
        S_FRONT_RD  = 15'h0020,
        S_FRONT_CHK = 15'h0040,
        S_DIV       = 15'h0080,
        S_DIV_WAIT  = 15'h0100,
        S_MUL1      = 15'h0200,
        S_MUL2      = 15'h0400,
        S_GAIN      = 15'h0800,
        S_SCL_L     = 15'h1000,
        S_SCL_R     = 15'h2000,
        S_FIN       = 15'h4000
    } state_t;

    // saturated magnitude of an input sample
    function automatic logic [PW-1:0] mag_sat(input logic [SB-1:0] v);
        logic [SB-1:0] n;
        n = ~v + 1'b1;
        if (!v[SB-1])
            return v[PW-1:0];
        else if (n[SB-1])
            return PEAK_MAX;
        else
            return n[PW-1:0];
    endfunction

    function automatic logic [SB-1:0] abs_val(input logic [SB-1:0] v);
        return v[SB-1] ? (~v + 1'b1) : v;
    endfunction

    // round at bit 23, clamp to ceiling, restore sign
    function automatic logic [SB-1:0] scale_out(input logic [PRD_W-1:0] p,
                                                input logic neg,
                                                input logic [CW-1:0] ceil);
        logic [PRD_W:0]   s;
        logic [RND_W-1:0] r;
        logic [CW-1:0]    m;
        logic [EXT_W-1:0] e;
        s = {1'b0, p} + (PRD_W+1)'(1 << (GF - 1));
        r = s[PRD_W:GF];
        m = (r > RND_W'(ceil)) ? ceil : r[CW-1:0];
        e = EXT_W'(m);
        if (neg)
            e = ~e + 1'b1;
        return e[SB-1:0];
    endfunction

    function automatic logic [DQ_W-1:0] dq_inc(input logic [DQ_W-1:0] p);
        return (p == DQ_W'(DEQUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [DQ_W-1:0] dq_dec(input logic [DQ_W-1:0] p);
        return (p == '0) ? DQ_W'(DEQUE_DEPTH - 1) : p - 1'b1;
    endfunction

    // configuration registers
    logic          mode_reg;
    logic [CW-1:0] ceil_reg;
    logic [KW-1:0] atk_reg;
    logic [KW-1:0] rel_reg;

    // sequencer and datapath state
    state_t        state_reg, state_next;
    logic [DQ_W-1:0] head_reg, head_next;
    logic [DQ_W-1:0] tail_reg, tail_next;
    logic [DQ_W-1:0] newest_reg, newest_next;
    logic [DQ_W-1:0] back_reg, back_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [PW-1:0] m_reg, m_next;
    logic [PW-1:0] wmax_reg, wmax_next;
    logic [GW-1:0] gain_reg, gain_next;
    logic [GW-1:0] greq_reg, greq_next;
    logic [KW-1:0] coef_reg, coef_next;
    logic [PRD_W-1:0] acc_reg, acc_next;
    logic [LA_W-1:0] dpos_reg, dpos_next;
    logic [LA_W-1:0] clr_reg, clr_next;
    logic [SB-1:0] lres_reg, lres_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [SB-1:0] out_left_reg, out_left_next;
    logic [SB-1:0] out_right_reg, out_right_next;
    logic [GW-1:0] out_gain_reg, out_gain_next;

    // deque memory: peak above stamp
    logic [PW+SW-1:0] dq_mem [DEQUE_DEPTH];
    logic [PW+SW-1:0] dq_rd_reg;
    logic             dq_we, dq_re;
    logic [DQ_W-1:0]  dq_waddr, dq_raddr;
    logic [PW+SW-1:0] dq_wdata;
    logic [PW-1:0]    rd_peak;
    logic [SW-1:0]    rd_stamp;
    logic [SW-1:0]    age;

    // delay line memories
    logic [SB-1:0]   dl_mem [LOOKAHEAD];
    logic [SB-1:0]   dr_mem [LOOKAHEAD];
    logic [SB-1:0]   dl_rd_reg, dr_rd_reg;
    logic            dly_we_l, dly_we_r, dly_re;
    logic [LA_W-1:0] dly_addr;
    logic [SB-1:0]   dly_wl, dly_wr;

    // shared units
    logic [MW-1:0]    mul_a;
    logic [GW-1:0]    mul_b;
    logic [PRD_W-1:0] prod;
    logic             div_start, div_done;
    logic [GF-1:0]    div_quot;

    logic          in_acc, out_fire;
    logic [PW-1:0] mag_l, mag_r;
    logic [PRD_W:0] gsum;

    assign sample_in.ready = (state_reg == S_IDLE);
    assign in_acc   = sample_in.valid & sample_in.ready;
    assign out_fire = out_valid_reg & result_out.ready;
    assign cfg.ready = 1'b1;

    assign mag_l    = mag_sat(sample_in.left_in);
    assign mag_r    = mag_sat(sample_in.right_in);
    assign rd_peak  = dq_rd_reg[PW+SW-1:SW];
    assign rd_stamp = dq_rd_reg[SW-1:0];
    assign age      = idx_reg - rd_stamp;
    assign gsum     = {1'b0, acc_reg} + {1'b0, prod} + (PRD_W+1)'(1 << (KW - 1));

    // configuration writes; unlisted indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lpl_pkg::MODE_RST;
            ceil_reg <= lpl_pkg::CEILING_RST;
            atk_reg  <= lpl_pkg::ATTACK_RST;
            rel_reg  <= lpl_pkg::RELEASE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lpl_pkg::REG_CHANNEL_MODE:  mode_reg <= cfg.data[0];
                lpl_pkg::REG_CEILING_LEVEL: ceil_reg <= cfg.data[CW-1:0];
                lpl_pkg::REG_ATTACK_COEF:   atk_reg  <= cfg.data[KW-1:0];
                lpl_pkg::REG_RELEASE_COEF:  rel_reg  <= cfg.data[KW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        newest_next = newest_reg;
        back_next   = back_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        m_next      = m_reg;
        wmax_next   = wmax_reg;
        gain_next   = gain_reg;
        greq_next   = greq_reg;
        coef_next   = coef_reg;
        acc_next    = acc_reg;
        dpos_next   = dpos_reg;
        clr_next    = clr_reg;
        lres_next   = lres_reg;

        out_valid_next = out_valid_reg & ~out_fire;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_gain_next  = out_gain_reg;

        dq_we    = 1'b0;
        dq_re    = 1'b0;
        dq_waddr = tail_reg;
        dq_raddr = head_reg;
        dq_wdata = {m_reg, idx_reg};

        dly_we_l = 1'b0;
        dly_we_r = 1'b0;
        dly_re   = 1'b0;
        dly_addr = dpos_reg;
        dly_wl   = sample_in.left_in;
        dly_wr   = sample_in.right_in;

        mul_a     = '0;
        mul_b     = gain_reg;
        div_start = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                // zero both delay lines
                dly_we_l = 1'b1;
                dly_we_r = 1'b1;
                dly_addr = clr_reg;
                dly_wl   = '0;
                dly_wr   = '0;
                if (clr_reg == LA_W'(LOOKAHEAD - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    m_next   = (mode_reg && (mag_r > mag_l)) ? mag_r : mag_l;
                    idx_next = cnt_reg;
                    cnt_next = cnt_reg + 1'b1;
                    // read the oldest sample, write the new one in its place (the right line only in stereo mode)
                    dly_re   = 1'b1;
                    dly_we_l = 1'b1;
                    dly_we_r = mode_reg;
                    dpos_next = (dpos_reg == LA_W'(LOOKAHEAD - 1)) ? '0
                                                                   : dpos_reg + 1'b1;
                    state_next = S_BACK_RD;
                end
            end
            S_BACK_RD:
            begin
                if (head_reg == tail_reg)
                    state_next = S_PUSH;
                else
                begin
                    back_next  = dq_dec(tail_reg);
                    dq_re      = 1'b1;
                    dq_raddr   = dq_dec(tail_reg);
                    state_next = S_BACK_CHK;
                end
            end
            S_BACK_CHK:
            begin
                // entries no larger than the new peak can never be the max
                if (rd_peak <= m_reg)
                begin
                    tail_next  = back_reg;
                    state_next = S_BACK_RD;
                end
                else
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (dq_inc(tail_reg) == head_reg)
                    head_next = dq_inc(head_reg);
                dq_we       = 1'b1;
                newest_next = tail_reg;
                tail_next   = dq_inc(tail_reg);
                state_next  = S_FRONT_RD;
            end
            S_FRONT_RD:
            begin
                // the newest entry is always inside the window
                if (head_reg == newest_reg)
                begin
                    wmax_next  = m_reg;
                    state_next = S_DIV;
                end
                else
                begin
                    dq_re      = 1'b1;
                    state_next = S_FRONT_CHK;
                end
            end
            S_FRONT_CHK:
            begin
                if (age >= SW'(LOOKAHEAD))
                begin
                    head_next  = dq_inc(head_reg);
                    state_next = S_FRONT_RD;
                end
                else
                begin
                    wmax_next  = rd_peak;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (CMP_W'(wmax_reg) > CMP_W'(ceil_reg))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_WAIT;
                end
                else
                begin
                    greq_next  = lpl_pkg::GAIN_ONE;
                    state_next = S_MUL1;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    greq_next  = GW'(div_quot);
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                // attack when the gain falls, release when it rises
                coef_next  = (greq_reg < gain_reg) ? atk_reg : rel_reg;
                mul_a      = MW'((greq_reg < gain_reg) ? atk_reg : rel_reg);
                mul_b      = gain_reg;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next   = prod;
                mul_a      = MW'(lpl_pkg::COEF_ONE - {1'b0, coef_reg});
                mul_b      = greq_reg;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                gain_next  = gsum[KW +: GW];
                state_next = S_SCL_L;
            end
            S_SCL_L:
            begin
                mul_a      = MW'(abs_val(dl_rd_reg));
                mul_b      = gain_reg;
                state_next = S_SCL_R;
            end
            S_SCL_R:
            begin
                lres_next  = scale_out(prod, dl_rd_reg[SB-1], ceil_reg);
                mul_a      = MW'(abs_val(dr_rd_reg));
                mul_b      = gain_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // keep the right product steady while waiting
                mul_a = MW'(abs_val(dr_rd_reg));
                mul_b = gain_reg;
                // wait for the output register to free up
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_left_next  = lres_reg;
                    out_right_next = mode_reg ? scale_out(prod, dr_rd_reg[SB-1], ceil_reg)
                                              : '0;
                    out_gain_next  = gain_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            gain_reg      <= lpl_pkg::GAIN_ONE;
            dpos_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            gain_reg      <= gain_next;
            dpos_reg      <= dpos_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_reg    <= newest_next;
        back_reg      <= back_next;
        idx_reg       <= idx_next;
        m_reg         <= m_next;
        wmax_reg      <= wmax_next;
        greq_reg      <= greq_next;
        coef_reg      <= coef_next;
        acc_reg       <= acc_next;
        lres_reg      <= lres_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_gain_reg  <= out_gain_next;
    end

    // deque memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (dq_we)
            dq_mem[dq_waddr] <= dq_wdata;
        if (dq_re)
            dq_rd_reg <= dq_mem[dq_raddr];
    end

    // delay lines, read-before-write at the same address
    always_ff @(posedge clk)
    begin
        if (dly_we_l)
            dl_mem[dly_addr] <= dly_wl;
        if (dly_re)
            dl_rd_reg <= dl_mem[dly_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dly_we_r)
            dr_mem[dly_addr] <= dly_wr;
        if (dly_re)
            dr_rd_reg <= dr_mem[dly_addr];
    end

    lpl_div #(
        .PW (PW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ceil_reg),
        .den   (wmax_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    lpl_mul #(
        .AW (MW),
        .BW (GW)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign result_out.valid     = out_valid_reg;
    assign result_out.left_out  = out_left_reg;
    assign result_out.right_out = out_right_reg;
    assign result_out.gain_now  = out_gain_reg;

    // smoothed gain never exceeds unity
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= lpl_pkg::GAIN_ONE)
        else $error("smoothed gain above unity");

    // a push always leaves the deque non-empty
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |=> (head_reg != tail_reg))
        else $error("deque empty after push");

    // a new result only appears from the final sequencer step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside final step");

    // a divide is only awaited after it was started
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT) && $past(state_reg == S_DIV) |-> $past(div_start))
        else $error("divider wait without start");
endmodule

// File: tb/tb_top.sv
// testbench for lookahead_peak_limiter_core: directed table then random sample pairs
// depends on lpl_pkg, lpl_ifs and the core; predicts each result and compares it field by field
module tb_top;
    localparam int LA = lpl_pkg::LOOKAHEAD_DEF;
    localparam int DD = lpl_pkg::DEQUE_DEPTH_DEF;
    localparam int SB = lpl_pkg::SAMPLE_BITS_DEF;
    localparam int GAIN_W = lpl_pkg::GAIN_W;
    localparam int CEIL_W = lpl_pkg::CEIL_W;
    localparam int COEF_W = lpl_pkg::COEF_W;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int N_DIRECTED = 20;

    logic clk;
    logic rst_n;

    lpl_sample_if #(.SB(SB)) sample_ch ();
    lpl_result_if #(.SB(SB)) result_ch ();
    lpl_cfg_if               cfg_ch ();

    lookahead_peak_limiter_core #(
        .LOOKAHEAD(LA),
        .DEQUE_DEPTH(DD),
        .SAMPLE_BITS(SB)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_in(sample_ch.sink),
        .result_out(result_ch.source),
        .cfg(cfg_ch.sink)
    );

    typedef struct packed {
        logic [SB-1:0]     left;
        logic [SB-1:0]     right;
        logic [GAIN_W-1:0] gain;
    } limited_t;

    // directed row: inputs plus an optional typed-in expectation
    typedef struct {
        logic [SB-1:0]     left;
        logic [SB-1:0]     right;
        bit                known;
        logic [GAIN_W-1:0] gain;
    } stim_row_t;

    // predictor copy of the block
    bit                mode_q;
    logic [CEIL_W-1:0] ceil_q;
    logic [COEF_W-1:0] atk_q;
    logic [COEF_W-1:0] rel_q;
    logic [CEIL_W-1:0] peak_mem [DD];
    logic [15:0]       stamp_mem [DD];
    int unsigned       head_q, tail_q, wpos_q;
    logic [15:0]       count_q;
    logic [GAIN_W-1:0] gain_q;
    logic [SB-1:0]     dly_l [LA];
    logic [SB-1:0]     dly_r [LA];

    limited_t    pending_q[$];
    int unsigned errors;
    int unsigned cycles;
    int unsigned send_idle_pct, recv_idle_pct;

    // magnitude with the most negative value saturated
    function automatic logic [CEIL_W-1:0] abs_peak(logic [SB-1:0] s);
        logic [SB-1:0] m;
        m = s[SB-1] ? -s : s;
        if (m[SB-1]) return {CEIL_W{1'b1}};
        return m[CEIL_W-1:0];
    endfunction

    function automatic logic [SB-1:0] apply_gain(logic [SB-1:0] s, logic [GAIN_W-1:0] g,
                                                 logic [CEIL_W-1:0] c);
        logic [63:0] m;
        bit neg;
        neg = s[SB-1];
        m = neg ? 64'(-$signed(s)) : 64'(s);
        m = (m * g + 64'd4194304) >> 23;
        if (m > c) m = c;
        return neg ? SB'(-m) : SB'(m);
    endfunction

    function automatic limited_t limit_sample(logic [SB-1:0] l, logic [SB-1:0] r);
        logic [CEIL_W-1:0] m, mr, wmax;
        logic [15:0]       stamp;
        logic [63:0]       greq, coef, acc;
        int unsigned       back, newest;
        limited_t          res;
        m = abs_peak(l);
        if (mode_q)
        begin
            mr = abs_peak(r);
            if (mr > m) m = mr;
        end
        stamp = count_q;
        count_q = count_q + 16'd1;
        while (head_q != tail_q)
        begin
            back = (tail_q + DD - 1) % DD;
            if (peak_mem[back] <= m) tail_q = back;
            else break;
        end
        if ((tail_q + 1) % DD == head_q) head_q = (head_q + 1) % DD;
        newest = tail_q;
        peak_mem[newest] = m;
        stamp_mem[newest] = stamp;
        tail_q = (tail_q + 1) % DD;
        while (head_q != newest && 16'(stamp - stamp_mem[head_q]) >= LA)
            head_q = (head_q + 1) % DD;
        wmax = peak_mem[head_q];
        if (wmax > ceil_q) greq = (64'(ceil_q) << 23) / wmax;
        else greq = 64'(lpl_pkg::GAIN_ONE);
        coef = (greq < gain_q) ? atk_q : rel_q;
        acc = coef * gain_q + (64'(lpl_pkg::COEF_ONE) - coef) * greq + 64'd8388608;
        gain_q = GAIN_W'(acc >> 24);
        res.left = apply_gain(dly_l[wpos_q], gain_q, ceil_q);
        dly_l[wpos_q] = l;
        res.right = '0;
        if (mode_q)
        begin
            res.right = apply_gain(dly_r[wpos_q], gain_q, ceil_q);
            dly_r[wpos_q] = r;
        end
        wpos_q = (wpos_q + 1) % LA;
        res.gain = gain_q;
        return res;
    endfunction

    // clock: 12 units
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result checker at the rising edge; receiver-side stalls come from the falling edge
    always @(posedge clk)
    begin
        limited_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= 10) $display("unexpected result item l=%h r=%h g=%h",
                    result_ch.left_out, result_ch.right_out, result_ch.gain_now);
            end
            else
            begin
                want = pending_q.pop_front();
                if (want.left !== result_ch.left_out || want.right !== result_ch.right_out
                    || want.gain !== result_ch.gain_now)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("mismatch: exp l=%h r=%h g=%h got l=%h r=%h g=%h",
                            want.left, want.right, want.gain, result_ch.left_out,
                            result_ch.right_out, result_ch.gain_now);
                end
            end
        end
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // one config write while the block is idle; predictor follows it
    task automatic write_reg(logic [lpl_pkg::CFG_IDX_W-1:0] idx,
                             logic [lpl_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            lpl_pkg::REG_CHANNEL_MODE:  mode_q = val[0];
            lpl_pkg::REG_CEILING_LEVEL: ceil_q = val[CEIL_W-1:0];
            lpl_pkg::REG_ATTACK_COEF:   atk_q  = val;
            lpl_pkg::REG_RELEASE_COEF:  rel_q  = val;
            default: ;
        endcase
    endtask

    // send one pair; the expectation is queued at the accepting edge
    task automatic send_pair(logic [SB-1:0] l, logic [SB-1:0] r, bit known,
                             logic [GAIN_W-1:0] gain_typed);
        limited_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.left_in  <= l;
        sample_ch.right_in <= r;
        do @(posedge clk); while (!sample_ch.ready);
        res = limit_sample(l, r);
        if (known && res.gain !== gain_typed)
        begin
            // typed-in value disagrees with prediction: the table wins
            errors = errors + 1;
            if (errors <= 10) $display("table gain %h vs predicted %h", gain_typed, res.gain);
            res.gain = gain_typed;
        end
        pending_q.push_back(res);
        @(negedge clk);
    endtask

    task automatic drain_all();
        sample_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic logic [SB-1:0] rand_sample(int unsigned kind);
        case (kind)
            0: return SB'($urandom);
            1: return SB'($signed($urandom_range(8388607)) >>> $urandom_range(12));
            2: return $urandom_range(1) ? SB'(24'h800000) : SB'(24'h7FFFFF);
            default: return SB'($urandom_range(4194304)) ^ ($urandom_range(1) ? '1 : '0);
        endcase
    endfunction

    task automatic random_burst(int unsigned n);
        int unsigned kind;
        repeat (n)
        begin
            kind = $urandom_range(3);
            send_pair(rand_sample(kind), rand_sample(kind), 1'b0, '0);
        end
    endtask

    stim_row_t directed [N_DIRECTED];

    initial
    begin
        // after reset: silence keeps gain at one; extremes drive it down
        directed[0]  = '{24'h000000, 24'h000000, 1'b1, lpl_pkg::GAIN_ONE};
        directed[1]  = '{24'h000000, 24'h000000, 1'b1, lpl_pkg::GAIN_ONE};
        directed[2]  = '{24'h400000, 24'hC00000, 1'b1, lpl_pkg::GAIN_ONE};
        directed[3]  = '{24'h7FFFFF, 24'h000000, 1'b0, '0};
        directed[4]  = '{24'h800000, 24'h800000, 1'b0, '0};
        directed[5]  = '{24'h000001, 24'hFFFFFF, 1'b0, '0};
        directed[6]  = '{24'h000000, 24'h7FFFFF, 1'b0, '0};
        directed[7]  = '{24'hC00000, 24'h400000, 1'b0, '0};
        directed[8]  = '{24'h555555, 24'hAAAAAA, 1'b0, '0};
        directed[9]  = '{24'hAAAAAA, 24'h555555, 1'b0, '0};
        directed[10] = '{24'h400001, 24'h3FFFFF, 1'b0, '0};
        directed[11] = '{24'h200000, 24'hE00000, 1'b0, '0};
        directed[12] = '{24'h100000, 24'h100000, 1'b0, '0};
        directed[13] = '{24'h7FFFFF, 24'h7FFFFF, 1'b0, '0};
        directed[14] = '{24'h800001, 24'h000000, 1'b0, '0};
        directed[15] = '{24'h000000, 24'h000000, 1'b0, '0};
        directed[16] = '{24'h0FFFFF, 24'hF00000, 1'b0, '0};
        directed[17] = '{24'h3FFFFF, 24'hC00001, 1'b0, '0};
        directed[18] = '{24'h012345, 24'hFEDCBA, 1'b0, '0};
        directed[19] = '{24'h000000, 24'h000000, 1'b0, '0};

        errors = 0;
        send_idle_pct = 18;
        recv_idle_pct = 81;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.left_in = '0;
        sample_ch.right_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;

        // predictor reset
        mode_q = lpl_pkg::MODE_RST;
        ceil_q = lpl_pkg::CEILING_RST;
        atk_q = lpl_pkg::ATTACK_RST;
        rel_q = lpl_pkg::RELEASE_RST;
        head_q = 0;
        tail_q = 0;
        wpos_q = 0;
        count_q = '0;
        gain_q = lpl_pkg::GAIN_ONE;
        foreach (dly_l[i]) begin dly_l[i] = '0; dly_r[i] = '0; end
        foreach (peak_mem[i]) begin peak_mem[i] = '0; stamp_mem[i] = '0; end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table at reset settings
        foreach (directed[i])
            send_pair(directed[i].left, directed[i].right, directed[i].known, directed[i].gain);
        random_burst(150);
        // pause the sender until every result is back
        drain_all();

        // mono, ceiling zero, fastest smoothing
        write_reg(lpl_pkg::REG_CHANNEL_MODE, 24'd0);
        write_reg(lpl_pkg::REG_CEILING_LEVEL, 24'd0);
        write_reg(lpl_pkg::REG_ATTACK_COEF, 24'd0);
        write_reg(lpl_pkg::REG_RELEASE_COEF, 24'd0);
        write_reg(8'd9, 24'hFFFFFF);
        random_burst(120);
        drain_all();

        // stereo, small ceiling, slowest smoothing
        send_idle_pct = 81;
        recv_idle_pct = 18;
        write_reg(lpl_pkg::REG_CHANNEL_MODE, 24'd1);
        write_reg(lpl_pkg::REG_CEILING_LEVEL, 24'd1);
        write_reg(lpl_pkg::REG_ATTACK_COEF, 24'hFFFFFF);
        write_reg(lpl_pkg::REG_RELEASE_COEF, 24'hFFFFFF);
        random_burst(200);
        drain_all();

        // top ceiling, random coefficients
        write_reg(lpl_pkg::REG_CEILING_LEVEL, 24'h7FFFFF);
        write_reg(lpl_pkg::REG_ATTACK_COEF, 24'($urandom));
        write_reg(lpl_pkg::REG_RELEASE_COEF, 24'($urandom));
        random_burst(300);
        drain_all();

        // no idling; several random settings
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4)
        begin
            write_reg(lpl_pkg::REG_CHANNEL_MODE, 24'($urandom_range(1)));
            write_reg(lpl_pkg::REG_CEILING_LEVEL, 24'($urandom_range(4194304)));
            write_reg(lpl_pkg::REG_ATTACK_COEF, 24'($urandom_range(16777215, 12000000)));
            write_reg(lpl_pkg::REG_RELEASE_COEF, 24'($urandom_range(16777215, 14000000)));
            random_burst(200);
            drain_all();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
